// ===== design/dgcc_pkg.sv =====
// shared types, constants and helpers for the directed graph store
// depends on nothing
package dgcc_pkg;

   localparam int VERTICES     = 16;
   localparam int VERTEX_WIDTH = 4;
   localparam int OP_WIDTH     = 3;

   localparam logic [OP_WIDTH-1:0] OP_ADD_VERTEX = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_ADD_EDGE   = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_QUERY_EDGE = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_SUCC       = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_PRED       = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_CYCLE      = 3'd5;

   // adjacency read address source
   localparam logic [1:0] RD_REQ   = 2'd0;
   localparam logic [1:0] RD_IDX   = 2'd1;
   localparam logic [1:0] RD_FRONT = 2'd2;

   // result kinds
   localparam logic [1:0] EMIT_QUERY   = 2'd0;
   localparam logic [1:0] EMIT_CYC_NO  = 2'd1;
   localparam logic [1:0] EMIT_CYC_YES = 2'd2;
   localparam logic [1:0] EMIT_LIST    = 2'd3;

   typedef struct packed {
      logic [OP_WIDTH-1:0]     op;
      logic [VERTEX_WIDTH-1:0] vertex_a;
      logic [VERTEX_WIDTH-1:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic                    answer_bit;
      logic [VERTEX_WIDTH-1:0] neighbor;
      logic                    list_empty;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       add_vertex;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_edge;
      logic       set_clear;
      logic       set_load_row;
      logic       set_pred_bit;
      logic       set_pop;
      logic       idx_clear;
      logic       idx_inc;
      logic       todo_load;
      logic       start_pick;
      logic       visit;
      logic       expand;
      logic       emit;
      logic [1:0] emit_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic set_empty;
      logic set_one;
      logic todo_empty;
      logic frontier_empty;
      logic hits_start;
      logic idx_last;
   } dp_status_type;

   function automatic logic [VERTICES-1:0] vertex_bit(input logic [VERTEX_WIDTH-1:0] v);
      vertex_bit = {{(VERTICES-1){1'b0}}, 1'b1} << v;
   endfunction

   // index of the lowest set bit, zero when none
   function automatic logic [VERTEX_WIDTH-1:0] lowest_bit(input logic [VERTICES-1:0] m);
      lowest_bit = '0;
      for (int i = VERTICES - 1; i >= 0; i--) begin
         if (m[i]) lowest_bit = VERTEX_WIDTH'(i);
      end
   endfunction

endpackage

// ===== design/dgcc_datapath.sv =====
// datapath: adjacency memory, vertex masks, search masks and result register
// depends on dgcc_pkg
module dgcc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  dgcc_pkg::req_type      req_data,
   input  dgcc_pkg::dp_cmd_type   cmd,
   output dgcc_pkg::dp_status_type status,
   output logic                   rsp_strobe,
   output dgcc_pkg::rsp_type      rsp_data
);
   import dgcc_pkg::*;

   logic [VERTICES-1:0]     adj_mem [VERTICES];
   logic [VERTICES-1:0]     row_valid_ff;
   logic [VERTICES-1:0]     rd_data_ff;
   logic                    rd_valid_ff;
   logic [VERTICES-1:0]     rd_row;
   logic [VERTEX_WIDTH-1:0] rd_addr;

   logic [VERTEX_WIDTH-1:0] a_ff, b_ff;
   logic [VERTICES-1:0]     present_ff, set_ff, todo_ff, start_ff;
   logic [VERTICES-1:0]     visited_ff, frontier_ff;
   logic [VERTEX_WIDTH-1:0] idx_ff;
   logic [VERTEX_WIDTH-1:0] set_low, front_low, todo_low;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_ff, rsp_in;

   assign rd_row    = rd_valid_ff ? rd_data_ff : '0;
   assign set_low   = lowest_bit(set_ff);
   assign front_low = lowest_bit(frontier_ff);
   assign todo_low  = lowest_bit(todo_ff);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_REQ:   rd_addr = req_data.vertex_a;
         RD_IDX:   rd_addr = idx_ff;
         RD_FRONT: rd_addr = front_low;
         default:  rd_addr = idx_ff;
      endcase
   end

   // adjacency rows, one read or one write a cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_edge) adj_mem[a_ff] <= rd_row | vertex_bit(b_ff);
      if (cmd.rd_en) rd_data_ff <= adj_mem[rd_addr];
   end

   // rows never written read as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.wr_edge) row_valid_ff[a_ff] <= 1'b1;
         if (cmd.rd_en) rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         a_ff <= req_data.vertex_a;
         b_ff <= req_data.vertex_b;
      end
      if (cmd.idx_clear) idx_ff <= '0;
      else if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
      if (cmd.set_clear) set_ff <= '0;
      else if (cmd.set_load_row) set_ff <= rd_row;
      else if (cmd.set_pred_bit) set_ff[idx_ff] <= rd_row[a_ff];
      else if (cmd.set_pop) set_ff[set_low] <= 1'b0;
      if (cmd.todo_load) todo_ff <= present_ff;
      else if (cmd.start_pick) todo_ff[todo_low] <= 1'b0;
      if (cmd.start_pick) start_ff <= vertex_bit(todo_low);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= '0;
         visited_ff  <= '0;
         frontier_ff <= '0;
      end else begin
         if (cmd.add_vertex) present_ff <= present_ff | vertex_bit(req_data.vertex_a);
         if (cmd.start_pick) begin
            visited_ff  <= '0;
            frontier_ff <= vertex_bit(todo_low);
         end else if (cmd.visit) begin
            visited_ff[front_low]  <= 1'b1;
            frontier_ff[front_low] <= 1'b0;
         end else if (cmd.expand) begin
            frontier_ff <= frontier_ff | (rd_row & ~visited_ff);
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      unique case (cmd.emit_kind)
         EMIT_QUERY: begin
            rsp_in.answer_bit = rd_row[b_ff];
            rsp_in.last       = 1'b1;
         end
         EMIT_CYC_NO: begin
            rsp_in.last = 1'b1;
         end
         EMIT_CYC_YES: begin
            rsp_in.answer_bit = 1'b1;
            rsp_in.last       = 1'b1;
         end
         EMIT_LIST: begin
            rsp_in.neighbor   = set_low;
            rsp_in.list_empty = status.set_empty;
            rsp_in.last       = status.set_empty | status.set_one;
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else rsp_strobe_ff <= cmd.emit;
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign status.set_empty      = (set_ff == '0);
   assign status.set_one        = ((set_ff & (set_ff - VERTICES'(1))) == '0);
   assign status.todo_empty     = (todo_ff == '0);
   assign status.frontier_empty = (frontier_ff == '0);
   assign status.hits_start     = ((rd_row & start_ff) != '0);
   assign status.idx_last       = (idx_ff == VERTEX_WIDTH'(VERTICES - 1));

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== design/dgcc_controller.sv =====
// controller state machine sequencing each operation over the datapath
// depends on dgcc_pkg
module dgcc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [dgcc_pkg::OP_WIDTH-1:0] req_op,
   input  dgcc_pkg::dp_status_type status,
   output logic                    busy,
   output dgcc_pkg::dp_cmd_type    cmd
);
   import dgcc_pkg::*;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_EDGE_WR    = 4'd1;
   localparam logic [3:0] ST_QUERY      = 4'd2;
   localparam logic [3:0] ST_LOAD       = 4'd3;
   localparam logic [3:0] ST_LIST       = 4'd4;
   localparam logic [3:0] ST_PRED_RD    = 4'd5;
   localparam logic [3:0] ST_PRED_ACC   = 4'd6;
   localparam logic [3:0] ST_NEXT_START = 4'd7;
   localparam logic [3:0] ST_VISIT      = 4'd8;
   localparam logic [3:0] ST_EXPAND     = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_op)
                  OP_ADD_VERTEX: cmd.add_vertex = 1'b1;
                  OP_ADD_EDGE: begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_EDGE_WR;
                  end
                  OP_QUERY_EDGE: begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_QUERY;
                  end
                  OP_SUCC: begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_LOAD;
                  end
                  OP_PRED: begin
                     cmd.set_clear = 1'b1;
                     cmd.idx_clear = 1'b1;
                     state_in      = ST_PRED_RD;
                  end
                  OP_CYCLE: begin
                     cmd.todo_load = 1'b1;
                     state_in      = ST_NEXT_START;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EDGE_WR: begin
            cmd.wr_edge = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_QUERY: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = EMIT_QUERY;
            state_in      = ST_IDLE;
         end
         ST_LOAD: begin
            cmd.set_load_row = 1'b1;
            state_in         = ST_LIST;
         end
         ST_LIST: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = EMIT_LIST;
            cmd.set_pop   = 1'b1;
            if (status.set_empty || status.set_one) state_in = ST_IDLE;
         end
         ST_PRED_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = ST_PRED_ACC;
         end
         ST_PRED_ACC: begin
            cmd.set_pred_bit = 1'b1;
            if (status.idx_last) begin
               state_in = ST_LIST;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_PRED_RD;
            end
         end
         ST_NEXT_START: begin
            if (status.todo_empty) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_CYC_NO;
               state_in      = ST_IDLE;
            end else begin
               cmd.start_pick = 1'b1;
               state_in       = ST_VISIT;
            end
         end
         ST_VISIT: begin
            if (status.frontier_empty) begin
               state_in = ST_NEXT_START;
            end else begin
               cmd.visit  = 1'b1;
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_FRONT;
               state_in   = ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            if (status.hits_start) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_CYC_YES;
               state_in      = ST_IDLE;
            end else begin
               cmd.expand = 1'b1;
               state_in   = ST_VISIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== design/directed_graph_store_cycle_check.sv =====
// query reads the row then emits; successors read the row, load it into the set, then list it;
// predecessors read every row in turn to build the set, then list it; lists then give one result
// per cycle; cycle check picks each registered start in turn and visits then expands each vertex
// reached from it; add vertex needs no later step, add edge reads the row then writes it back;
// synchronous active-high reset empties the graph
// results leave through a register and are strobed for one cycle; the receiver cannot stall
module directed_graph_store_cycle_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dgcc_pkg::req_type req_data,
   output logic              rsp_strobe,
   output dgcc_pkg::rsp_type rsp_data
);
   import dgcc_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: one item at a time, busy while its steps run
   dgcc_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // adjacency rows, vertex mask, search masks and the result register
   dgcc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
